// ===== rtl/active_reference_lifecycle_tracker_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef ACTIVE_REFERENCE_LIFECYCLE_TRACKER_MACROS_SVH
`define ACTIVE_REFERENCE_LIFECYCLE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ARLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ARLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/arlt_pkg.sv =====
package arlt_pkg;

    localparam int PHASE_BITS = 3;
    localparam int IDX_BITS   = 6;
    localparam int OUT_COUNT_BITS = 16;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_NEW     = 3'd0,
        PH_ACTIVE  = 3'd1,
        PH_DEACT   = 3'd2,
        PH_DRAINED = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ACT_INIT       = 3'd0,
        ACT_ACTIVATE   = 3'd1,
        ACT_DEACTIVATE = 3'd2,
        ACT_ACQUIRE    = 3'd3,
        ACT_RELEASE    = 3'd4,
        ACT_CLEANUP    = 3'd5,
        ACT_QUERY      = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        WAKE_NONE = 2'd0,
        WAKE_ONE  = 2'd1,
        WAKE_ALL  = 2'd2
    } wake_t;

    // Status flags of one transaction, passed from update logic to the top level.
    typedef struct packed {
        logic  success;
        wake_t wake;
        logic  error;
    } flags_t;

endpackage

// ===== rtl/arlt_table_mem.sv =====
// Object table: one write port, one read port, registered read data.
module arlt_table_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 20
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/arlt_update.sv =====
// Lifecycle update of one table entry for one action.
module arlt_update #(
    parameter int COUNT_BITS = 16
) (
    input  logic [2:0]                       action,
    input  logic                             in_range,
    input  logic [arlt_pkg::PHASE_BITS-1:0]  phase_in,
    input  logic                             was_active_in,
    input  logic [COUNT_BITS-1:0]            count_in,
    output logic [arlt_pkg::PHASE_BITS-1:0]  phase_out,
    output logic                             was_active_out,
    output logic [COUNT_BITS-1:0]            count_out,
    output arlt_pkg::flags_t                 flags
);

    logic count_zero;
    logic count_sat;

    assign count_zero = (count_in == '0);
    assign count_sat  = (count_in == '1);

    always_comb
    begin
        phase_out      = phase_in;
        was_active_out = was_active_in;
        count_out      = count_in;
        flags.success  = 1'b0;
        flags.wake     = arlt_pkg::WAKE_NONE;
        flags.error    = 1'b0;
        if (!in_range)
        begin
            phase_out   = arlt_pkg::PH_NEW;
            count_out   = '0;
            flags.error = 1'b1;
        end
        else
        begin
            unique case (action)
                arlt_pkg::ACT_INIT:
                begin
                    phase_out      = arlt_pkg::PH_NEW;
                    count_out      = '0;
                    was_active_out = 1'b0;
                    flags.success  = 1'b1;
                end
                arlt_pkg::ACT_ACTIVATE:
                begin
                    if (phase_in == arlt_pkg::PH_NEW)
                    begin
                        phase_out     = arlt_pkg::PH_ACTIVE;
                        count_out     = '0;
                        flags.success = 1'b1;
                    end
                end
                arlt_pkg::ACT_DEACTIVATE:
                begin
                    if (phase_in == arlt_pkg::PH_NEW)
                    begin
                        phase_out      = arlt_pkg::PH_DRAINED;
                        count_out      = '0;
                        was_active_out = 1'b0;
                        flags.success  = 1'b1;
                    end
                    else if (phase_in == arlt_pkg::PH_ACTIVE)
                    begin
                        was_active_out = 1'b1;
                        phase_out      = count_zero ? arlt_pkg::PH_DRAINED : arlt_pkg::PH_DEACT;
                        flags.success  = 1'b1;
                    end
                end
                arlt_pkg::ACT_ACQUIRE:
                begin
                    if (phase_in == arlt_pkg::PH_ACTIVE && !count_sat)
                    begin
                        count_out     = count_in + 1'b1;
                        flags.success = 1'b1;
                    end
                end
                arlt_pkg::ACT_RELEASE:
                begin
                    if (count_zero)
                    begin
                        flags.error = 1'b1;
                    end
                    else
                    begin
                        count_out = count_in - 1'b1;
                        // last reference of a deactivated object
                        if (phase_in == arlt_pkg::PH_DEACT && count_in == COUNT_BITS'(1))
                        begin
                            phase_out  = arlt_pkg::PH_DRAINED;
                            flags.wake = arlt_pkg::WAKE_ONE;
                        end
                    end
                end
                arlt_pkg::ACT_CLEANUP:
                begin
                    if (phase_in == arlt_pkg::PH_DRAINED)
                    begin
                        phase_out     = arlt_pkg::PH_DONE;
                        flags.success = 1'b1;
                        flags.wake    = arlt_pkg::WAKE_ALL;
                    end
                    else if (phase_in != arlt_pkg::PH_DONE)
                    begin
                        flags.error = 1'b1;
                    end
                end
                arlt_pkg::ACT_QUERY:
                begin
                end
                default:
                begin
                    flags.error = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/active_reference_lifecycle_tracker.sv =====
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-------------------------------------------
// in      | input     | in_valid / in_stall   | action, object_index
// out     | output    | out_valid / out_stall | success, phase, ref_count, wake, error
//
// One transaction per cycle sustained while out_stall is low; from acceptance to result each passes the
// table read, then update and write-back into the result register. The table has one write and one read port.
// After reset a clearing pass writes every entry, with in_stall high throughout.
// out_stall holds the result register; the update stage then holds and in_stall rises.
module active_reference_lifecycle_tracker #(
    parameter int NUM_OBJECTS = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [5:0]  object_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    output logic [2:0]  phase,
    output logic [15:0] ref_count,
    output logic [1:0]  wake,
    output logic        error
);

    // Table address width, and a width that holds both the index port and an address.
    localparam int AW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int IW = (AW > arlt_pkg::IDX_BITS) ? AW : arlt_pkg::IDX_BITS;
    // Entry layout: {phase, was_active, count}.
    localparam int EW = arlt_pkg::PHASE_BITS + 1 + COUNT_BITS;
    // Width for taking the count to the 16-bit result port.
    localparam int RW = (COUNT_BITS > arlt_pkg::OUT_COUNT_BITS) ?
                        COUNT_BITS : arlt_pkg::OUT_COUNT_BITS;

    // Clearing pass after reset.
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Update stage: item whose entry is being read.
    logic          s1_valid_reg;
    logic [2:0]    s1_action_reg;
    logic          s1_in_range_reg;
    logic [AW-1:0] s1_addr_reg;
    // Write that landed on the same entry at the read edge.
    logic          byp_hit_reg;
    logic [EW-1:0] byp_data_reg;

    // Result register.
    logic          out_valid_reg;
    logic          success_reg;
    logic [2:0]    phase_reg;
    logic [15:0]   ref_count_reg;
    logic [1:0]    wake_reg;
    logic          error_reg;

    logic          in_acc;
    logic          s1_adv;
    logic          in_range;
    logic [IW-1:0] idx_wide;
    logic [AW-1:0] addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] entry;

    logic [arlt_pkg::PHASE_BITS-1:0] phase_n;
    logic                            was_active_n;
    logic [COUNT_BITS-1:0]           count_n;
    arlt_pkg::flags_t                flags;
    logic [RW-1:0]                   count_wide;

    assign in_range = (32'(object_index) < 32'(NUM_OBJECTS));
    assign idx_wide = IW'(object_index);
    assign addr     = idx_wide[AW-1:0];

    // Result register frees when empty or being taken this cycle.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clr_active_reg || (s1_valid_reg && !s1_adv);
    assign in_acc   = in_valid && !in_stall;

    // Write port: clearing pass, else write-back of the update stage.
    assign wr_en   = clr_active_reg || (s1_adv && s1_in_range_reg);
    assign wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_data = clr_active_reg ? '0 : {phase_n, was_active_n, count_n};

    arlt_table_mem #(
        .DEPTH (NUM_OBJECTS),
        .AW    (AW),
        .W     (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_acc),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Forward the previous write when it hit the entry being read.
    assign entry = byp_hit_reg ? byp_data_reg : rd_data;

    arlt_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .action         (s1_action_reg),
        .in_range       (s1_in_range_reg),
        .phase_in       (entry[EW-1 -: arlt_pkg::PHASE_BITS]),
        .was_active_in  (entry[COUNT_BITS]),
        .count_in       (entry[COUNT_BITS-1:0]),
        .phase_out      (phase_n),
        .was_active_out (was_active_n),
        .count_out      (count_n),
        .flags          (flags)
    );

    assign count_wide = RW'(count_n);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(NUM_OBJECTS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_action_reg   <= action;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= addr;
            byp_hit_reg     <= wr_en && (wr_addr == addr);
            byp_data_reg    <= wr_data;
        end
        if (s1_adv)
        begin
            success_reg   <= flags.success;
            phase_reg     <= phase_n;
            ref_count_reg <= count_wide[arlt_pkg::OUT_COUNT_BITS-1:0];
            wake_reg      <= flags.wake;
            error_reg     <= flags.error;
        end
    end

    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign phase     = phase_reg;
    assign ref_count = ref_count_reg;
    assign wake      = wake_reg;
    assign error     = error_reg;

endmodule

// ===== rtl/arlt_checker.sv =====
`include "active_reference_lifecycle_tracker_macros.svh"

module arlt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  action,
    input logic [5:0]  object_index,
    input logic        out_valid,
    input logic        out_stall,
    input logic        success,
    input logic [2:0]  phase,
    input logic [15:0] ref_count,
    input logic [1:0]  wake,
    input logic        error
);

    logic        in_wait;
    logic        out_wait;
    logic [8:0]  in_payload;
    logic [22:0] out_payload;
    logic        wake_all_res;
    logic        wake_one_res;
    logic        cleaned_up;
    logic        drained_quiet;

    assign in_wait       = in_valid && in_stall;
    assign out_wait      = out_valid && out_stall;
    assign in_payload    = {action, object_index};
    assign out_payload   = {success, phase, ref_count, wake, error};
    assign wake_all_res  = out_valid && (wake == arlt_pkg::WAKE_ALL);
    assign wake_one_res  = out_valid && (wake == arlt_pkg::WAKE_ONE);
    assign cleaned_up    = success && (phase == arlt_pkg::PH_DONE);
    assign drained_quiet = !success && !error && (phase == arlt_pkg::PH_DRAINED) &&
                           (ref_count == 16'd0);

    `ARLT_ASSERT_NXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_payload), "stalled transaction changed")
    `ARLT_ASSERT_NXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_payload), "stalled result changed")
    `ARLT_ASSERT_IMP(a_ok_err, clk, rst_n, out_valid, !(success && error), "success with error")
    `ARLT_ASSERT_IMP(a_wake_all, clk, rst_n, wake_all_res, cleaned_up, "wake all without cleanup to done")
    `ARLT_ASSERT_IMP(a_wake_one, clk, rst_n, wake_one_res, drained_quiet, "wake one without drain")

endmodule

bind active_reference_lifecycle_tracker arlt_checker u_arlt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .object_index (object_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .success      (success),
    .phase        (phase),
    .ref_count    (ref_count),
    .wake         (wake),
    .error        (error)
);
